// ===== rtl/aabb_box_operation_unit_defines.svh =====
// Assertion macros shared by the box operation unit.
`ifndef AABB_BOX_OPERATION_UNIT_DEFINES_SVH
`define AABB_BOX_OPERATION_UNIT_DEFINES_SVH

// Checked at each rising edge outside reset.
`define AABB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at each rising edge, reset included.
`define AABB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/aabb_pkg.sv =====
// Types and constants shared by the box operation unit.
package aabb_pkg;

	localparam int unsigned PORT_BITS    = 16;
	localparam int unsigned MEASURE_BITS = 48;

	typedef enum logic [3:0] {
		FN_LOAD       = 4'd0,
		FN_UNION_BOX  = 4'd1,
		FN_UNION_PT   = 4'd2,
		FN_INTERSECT  = 4'd3,
		FN_PT_INSIDE  = 4'd4,
		FN_BOX_INSIDE = 4'd5,
		FN_INSIDE_EQ  = 4'd6,
		FN_OVERLAP    = 4'd7,
		FN_EMPTY      = 4'd8,
		FN_VOLUME     = 4'd9,
		FN_SURFACE    = 4'd10
	} func_t;

	typedef struct packed {
		logic cap;
		logic box_go;
		logic mul1;
		logic mul2;
		logic fin;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_meas;
	} dp_sts_t;

endpackage

// ===== rtl/aabb_box_operation_unit.sv =====
// Top level of the 3D axis-aligned box operation unit.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | to unit   | in_valid, in_stall  | func, min_x/y/z, max_x/y/z
//   out     | from unit | out_valid, out_stall| flag, lo_x/y/z, hi_x/y/z, measure
//
// Box loads, unions, intersections and tests: capture, then evaluate once the output register is free.
// Volume and surface: capture, then two passes through the shared multiplier, then the final sum
// and saturation, which waits for a free output register.
// Reset is asynchronous; the stored box clears to all zero.
// A finished item waits in the output register while the next item is taken in; evaluation
// holds until that register is free.
module aabb_box_operation_unit #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         func,
	input  logic signed [15:0] min_x,
	input  logic signed [15:0] min_y,
	input  logic signed [15:0] min_z,
	input  logic signed [15:0] max_x,
	input  logic signed [15:0] max_y,
	input  logic signed [15:0] max_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               flag,
	output logic signed [15:0] lo_x,
	output logic signed [15:0] lo_y,
	output logic signed [15:0] lo_z,
	output logic signed [15:0] hi_x,
	output logic signed [15:0] hi_y,
	output logic signed [15:0] hi_z,
	output logic [47:0]        measure
);

	aabb_pkg::ctrl_cmd_t cmd;
	aabb_pkg::dp_sts_t   sts;

	aabb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	aabb_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.func    (func),
		.min_x   (min_x),
		.min_y   (min_y),
		.min_z   (min_z),
		.max_x   (max_x),
		.max_y   (max_y),
		.max_z   (max_z),
		.flag    (flag),
		.lo_x    (lo_x),
		.lo_y    (lo_y),
		.lo_z    (lo_z),
		.hi_x    (hi_x),
		.hi_y    (hi_y),
		.hi_z    (hi_z),
		.measure (measure)
	);

endmodule

// ===== rtl/aabb_ctrl.sv =====
// Controller state machine of the box operation unit.
`include "aabb_box_operation_unit_defines.svh"

module aabb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  aabb_pkg::dp_sts_t   sts,
	output aabb_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_MUL2 = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_meas) begin
					cmd.mul1 = 1'b1;
					state_d  = ST_MUL2;
				end else if (out_free) begin
					cmd.box_go = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.box_go || cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`AABB_ASSERT(a_accept_to_exec, (in_valid && !in_stall) |=> (state_q == ST_EXEC), "accepted item did not enter evaluation")
	`AABB_ASSERT(a_load_needs_room, (cmd.box_go || cmd.fin) |-> (!out_valid_q || !out_stall), "result loaded over a waiting item")
	`AABB_ASSERT(a_mul2_to_fin, (state_q == ST_MUL2) |=> (state_q == ST_FIN), "second product not followed by finish")
	`AABB_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!out_valid && !in_stall), "unit not quiet in reset")

endmodule

// ===== rtl/aabb_datapath.sv =====
// Datapath of the box operation unit: stored box, tests, shared multiplier.
module aabb_datapath #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aabb_pkg::ctrl_cmd_t cmd,
	output aabb_pkg::dp_sts_t   sts,
	input  logic [3:0]          func,
	input  logic signed [15:0]  min_x,
	input  logic signed [15:0]  min_y,
	input  logic signed [15:0]  min_z,
	input  logic signed [15:0]  max_x,
	input  logic signed [15:0]  max_y,
	input  logic signed [15:0]  max_z,
	output logic                flag,
	output logic signed [15:0]  lo_x,
	output logic signed [15:0]  lo_y,
	output logic signed [15:0]  lo_z,
	output logic signed [15:0]  hi_x,
	output logic signed [15:0]  hi_y,
	output logic signed [15:0]  hi_z,
	output logic [47:0]         measure
);

	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned PB = aabb_pkg::PORT_BITS;
	localparam int unsigned MB = aabb_pkg::MEASURE_BITS;
	localparam int unsigned PW = 3 * CW + 1;
	localparam int unsigned SW = (3 * CW + 3 > MB + 1) ? 3 * CW + 3 : MB + 1;

	typedef logic signed [CW-1:0] coord_t;

	function automatic coord_t cmin(coord_t a, coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic coord_t cmax(coord_t a, coord_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [PB-1:0] to_port(coord_t c);
		logic [CW+PB-1:0] sx;
		sx = {{PB{c[CW-1]}}, c};
		return sx[PB-1:0];
	endfunction

	logic [PB-1:0]    fld [6];
	logic [CW+PB-1:0] fld_ext [6];
	coord_t           fld_c [6];

	aabb_pkg::func_t  func_q;
	coord_t           in_q [6];
	coord_t           box_q [6];
	coord_t           box_d [6];
	logic             flag_d;

	logic             pin_a, pin_b, eq, ov, em;

	logic signed [CW:0] diff [3];
	logic signed [CW:0] mag [3];
	logic [CW-1:0]      edge_q [3];

	logic             is_surf;
	logic [2*CW-1:0]  mul_a;
	logic [CW:0]      mul_b;
	logic [PW-1:0]    mul_p;
	logic [PW-1:0]    p1_q, p2_q;
	logic [SW-1:0]    res;
	logic [MB-1:0]    meas_d;

	logic             flag_q;
	logic [PB-1:0]    out_c_q [6];
	logic [MB-1:0]    meas_q;

	assign fld[0] = min_x;
	assign fld[1] = min_y;
	assign fld[2] = min_z;
	assign fld[3] = max_x;
	assign fld[4] = max_y;
	assign fld[5] = max_z;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			fld_ext[i] = {{CW{1'b0}}, fld[i]};
			fld_c[i]   = coord_t'(fld_ext[i][CW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q <= aabb_pkg::func_t'(func);
			in_q   <= fld_c;
		end
	end

	assign is_surf     = (func_q == aabb_pkg::FN_SURFACE);
	assign sts.is_meas = (func_q == aabb_pkg::FN_VOLUME) || is_surf;

	always_comb begin
		pin_a = 1'b1;
		pin_b = 1'b1;
		eq    = 1'b1;
		ov    = 1'b1;
		em    = 1'b0;
		for (int a = 0; a < 3; a++) begin
			pin_a = pin_a && (in_q[a] > box_q[a]) && (in_q[a] < box_q[a+3]);
			pin_b = pin_b && (in_q[a+3] > box_q[a]) && (in_q[a+3] < box_q[a+3]);
			ov = ov && ((in_q[a] >= box_q[a] && in_q[a] <= box_q[a+3])
				|| (in_q[a+3] >= box_q[a] && in_q[a+3] <= box_q[a+3])
				|| (box_q[a] >= in_q[a] && box_q[a] <= in_q[a+3])
				|| (box_q[a+3] >= in_q[a] && box_q[a+3] <= in_q[a+3]));
			em = em || (box_q[a] >= box_q[a+3]);
		end
		for (int i = 0; i < 6; i++) begin
			eq = eq && (box_q[i] == in_q[i]);
		end

		box_d  = box_q;
		flag_d = 1'b0;
		case (func_q)
			aabb_pkg::FN_LOAD: begin
				box_d = in_q;
			end
			aabb_pkg::FN_UNION_BOX: begin
				for (int a = 0; a < 3; a++) begin
					box_d[a]   = cmin(cmin(box_q[a], box_q[a+3]), cmin(in_q[a], in_q[a+3]));
					box_d[a+3] = cmax(cmax(box_q[a], box_q[a+3]), cmax(in_q[a], in_q[a+3]));
				end
			end
			aabb_pkg::FN_UNION_PT: begin
				for (int a = 0; a < 3; a++) begin
					box_d[a]   = cmin(cmin(box_q[a], box_q[a+3]), in_q[a]);
					box_d[a+3] = cmax(cmax(box_q[a], box_q[a+3]), in_q[a]);
				end
			end
			aabb_pkg::FN_INTERSECT: begin
				for (int a = 0; a < 3; a++) begin
					box_d[a]   = cmax(box_q[a], in_q[a]);
					box_d[a+3] = cmin(box_q[a+3], in_q[a+3]);
				end
			end
			aabb_pkg::FN_PT_INSIDE:  flag_d = pin_a;
			aabb_pkg::FN_BOX_INSIDE: flag_d = pin_a && pin_b;
			aabb_pkg::FN_INSIDE_EQ:  flag_d = eq || (pin_a && pin_b);
			aabb_pkg::FN_OVERLAP:    flag_d = ov;
			aabb_pkg::FN_EMPTY:      flag_d = em;
			default: begin
				flag_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = {box_q[a+3][CW-1], box_q[a+3]} - {box_q[a][CW-1], box_q[a]};
			mag[a]  = diff[a][CW] ? -diff[a] : diff[a];
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			edge_q[a] <= mag[a][CW-1:0];
		end
	end

	always_comb begin
		if (cmd.mul2) begin
			if (is_surf) begin
				mul_a = {{CW{1'b0}}, edge_q[0]};
				mul_b = {1'b0, edge_q[1]} + {1'b0, edge_q[2]};
			end else begin
				mul_a = p1_q[2*CW-1:0];
				mul_b = {1'b0, edge_q[2]};
			end
		end else begin
			if (is_surf) begin
				mul_a = {{CW{1'b0}}, edge_q[1]};
				mul_b = {1'b0, edge_q[2]};
			end else begin
				mul_a = {{CW{1'b0}}, edge_q[0]};
				mul_b = {1'b0, edge_q[1]};
			end
		end
		mul_p = PW'(mul_a) * PW'(mul_b);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			p1_q <= mul_p;
		end
		if (cmd.mul2) begin
			p2_q <= mul_p;
		end
	end

	always_comb begin
		if (is_surf) begin
			res = (SW'(p1_q) + SW'(p2_q)) << 1;
		end else begin
			res = SW'(p2_q);
		end
		meas_d = (|res[SW-1:MB]) ? {MB{1'b1}} : res[MB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				box_q[i] <= '0;
			end
		end else if (cmd.box_go) begin
			box_q <= box_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.box_go) begin
			flag_q <= flag_d;
			meas_q <= '0;
			for (int i = 0; i < 6; i++) begin
				out_c_q[i] <= to_port(box_d[i]);
			end
		end else if (cmd.fin) begin
			flag_q <= 1'b0;
			meas_q <= meas_d;
			for (int i = 0; i < 6; i++) begin
				out_c_q[i] <= to_port(box_q[i]);
			end
		end
	end

	assign flag    = flag_q;
	assign lo_x    = out_c_q[0];
	assign lo_y    = out_c_q[1];
	assign lo_z    = out_c_q[2];
	assign hi_x    = out_c_q[3];
	assign hi_y    = out_c_q[4];
	assign hi_z    = out_c_q[5];
	assign measure = meas_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the 3D box operation unit: directed and random items.
`timescale 1ns / 1ps
module tb;

	typedef struct packed {
		logic [3:0]       fn;
		logic [5:0][15:0] c;
	} box_item_t;

	typedef struct packed {
		logic             flag;
		logic [5:0][15:0] c;
		logic [47:0]      measure;
	} box_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [3:0]         func = '0;
	logic signed [15:0] min_x = '0;
	logic signed [15:0] min_y = '0;
	logic signed [15:0] min_z = '0;
	logic signed [15:0] max_x = '0;
	logic signed [15:0] max_y = '0;
	logic signed [15:0] max_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               flag;
	logic signed [15:0] lo_x;
	logic signed [15:0] lo_y;
	logic signed [15:0] lo_z;
	logic signed [15:0] hi_x;
	logic signed [15:0] hi_y;
	logic signed [15:0] hi_z;
	logic [47:0]        measure;

	box_item_t        pending_items[$];
	box_result_t      expected_results[$];
	box_item_t        driven_item = '0;
	logic [5:0][15:0] stored_box = '0;
	int               send_gap_pct = 0;
	int               stall_pct = 0;
	int               errors = 0;
	string            corner_names[6] = '{"lo_x", "lo_y", "lo_z", "hi_x", "hi_y", "hi_z"};

	aabb_box_operation_unit dut (.*);

	always #1 clk = ~clk;

	function automatic longint coord(logic [15:0] v);
		longint r;
		r = $signed(v);
		return r;
	endfunction

	function automatic longint lmin(longint a, longint b);
		return a < b ? a : b;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return a > b ? a : b;
	endfunction

	function automatic box_result_t apply_box_op(box_item_t it);
		longint      s[6];
		longint      b[6];
		longint      e[3];
		longint      lo;
		longint      hi;
		longint      m;
		logic        pin;
		logic        qin;
		logic        same;
		logic        meet;
		logic        empty;
		box_result_t r;
		r = '0;
		m = 0;
		pin = 1'b1;
		qin = 1'b1;
		same = 1'b1;
		meet = 1'b1;
		empty = 1'b0;
		for (int i = 0; i < 6; i++) begin
			s[i] = coord(stored_box[i]);
			b[i] = coord(it.c[i]);
		end
		for (int a = 0; a < 3; a++) begin
			if (!(b[a] > s[a] && b[a] < s[a + 3]))
				pin = 1'b0;
			if (!(b[a + 3] > s[a] && b[a + 3] < s[a + 3]))
				qin = 1'b0;
			if (s[a] != b[a] || s[a + 3] != b[a + 3])
				same = 1'b0;
			if (!((b[a] >= s[a] && b[a] <= s[a + 3]) || (b[a + 3] >= s[a] && b[a + 3] <= s[a + 3])
					|| (s[a] >= b[a] && s[a] <= b[a + 3])
					|| (s[a + 3] >= b[a] && s[a + 3] <= b[a + 3])))
				meet = 1'b0;
			if (s[a] >= s[a + 3])
				empty = 1'b1;
			e[a] = s[a + 3] >= s[a] ? s[a + 3] - s[a] : s[a] - s[a + 3];
		end
		case (it.fn)
			aabb_pkg::FN_LOAD: begin
				for (int i = 0; i < 6; i++) begin
					s[i] = b[i];
				end
			end
			aabb_pkg::FN_UNION_BOX: begin
				for (int a = 0; a < 3; a++) begin
					lo = lmin(lmin(s[a], s[a + 3]), lmin(b[a], b[a + 3]));
					hi = lmax(lmax(s[a], s[a + 3]), lmax(b[a], b[a + 3]));
					s[a] = lo;
					s[a + 3] = hi;
				end
			end
			aabb_pkg::FN_UNION_PT: begin
				for (int a = 0; a < 3; a++) begin
					lo = lmin(lmin(s[a], s[a + 3]), b[a]);
					hi = lmax(lmax(s[a], s[a + 3]), b[a]);
					s[a] = lo;
					s[a + 3] = hi;
				end
			end
			aabb_pkg::FN_INTERSECT: begin
				for (int a = 0; a < 3; a++) begin
					s[a] = lmax(s[a], b[a]);
					s[a + 3] = lmin(s[a + 3], b[a + 3]);
				end
			end
			aabb_pkg::FN_PT_INSIDE: r.flag = pin;
			aabb_pkg::FN_BOX_INSIDE: r.flag = pin && qin;
			aabb_pkg::FN_INSIDE_EQ: r.flag = same || (pin && qin);
			aabb_pkg::FN_OVERLAP: r.flag = meet;
			aabb_pkg::FN_EMPTY: r.flag = empty;
			aabb_pkg::FN_VOLUME: m = e[0] * e[1] * e[2];
			aabb_pkg::FN_SURFACE: m = 2 * (e[0] * e[1] + e[0] * e[2] + e[1] * e[2]);
			default: ;
		endcase
		if (m > 64'hFFFF_FFFF_FFFF)
			m = 64'hFFFF_FFFF_FFFF;
		for (int i = 0; i < 6; i++) begin
			stored_box[i] = 16'(s[i]);
		end
		r.c = stored_box;
		r.measure = 48'(m);
		return r;
	endfunction

	task automatic check_field(string nm, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, nm, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		box_item_t next_item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_box_op(driven_item));
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					next_item = pending_items.pop_front();
					driven_item <= next_item;
					func <= next_item.fn;
					min_x <= next_item.c[0];
					min_y <= next_item.c[1];
					min_z <= next_item.c[2];
					max_x <= next_item.c[3];
					max_y <= next_item.c[4];
					max_z <= next_item.c[5];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		box_result_t got;
		box_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.flag = flag;
				got.c[0] = lo_x;
				got.c[1] = lo_y;
				got.c[2] = lo_z;
				got.c[3] = hi_x;
				got.c[4] = hi_y;
				got.c[5] = hi_z;
				got.measure = measure;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none actual flag %0b box %h measure %0d",
						$time, got.flag, got.c, got.measure);
				end else begin
					want = expected_results.pop_front();
					check_field("flag", want.flag, got.flag);
					for (int i = 0; i < 6; i++) begin
						check_field(corner_names[i], coord(want.c[i]), coord(got.c[i]));
					end
					check_field("measure", want.measure, got.measure);
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic queue_op(logic [3:0] fn, int x0, int y0, int z0, int x1, int y1, int z1);
		box_item_t it;
		it.fn = fn;
		it.c[0] = 16'(x0);
		it.c[1] = 16'(y0);
		it.c[2] = 16'(z0);
		it.c[3] = 16'(x1);
		it.c[4] = 16'(y1);
		it.c[5] = 16'(z1);
		pending_items.push_back(it);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 32) - 16);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom_range(0, 400) - 200);
		endcase
	endfunction

	task automatic queue_random_items(int n);
		box_item_t it;
		longint    lo;
		longint    hi;
		longint    span;
		int        made;
		made = 0;
		while (made < n) begin
			it.fn = 4'($urandom_range(0, 15));
			for (int i = 0; i < 6; i++) begin
				it.c[i] = rand_coord();
			end
			if ($urandom_range(0, 4) != 0) begin
				for (int a = 0; a < 3; a++) begin
					if ($signed(it.c[a]) > $signed(it.c[a + 3]))
						{it.c[a], it.c[a + 3]} = {it.c[a + 3], it.c[a]};
				end
			end
			if ($urandom_range(0, 4) == 0) begin
				it.fn = aabb_pkg::FN_LOAD;
				pending_items.push_back(it);
				case ($urandom_range(0, 2))
					0: it.fn = aabb_pkg::FN_INSIDE_EQ;
					1: begin
						it.fn = aabb_pkg::FN_BOX_INSIDE;
						for (int a = 0; a < 3; a++) begin
							lo = coord(it.c[a]);
							hi = coord(it.c[a + 3]);
							span = (hi - lo) / 3;
							it.c[a] = 16'(lo + span);
							it.c[a + 3] = 16'(hi - span);
						end
					end
					default: begin
						it.fn = aabb_pkg::FN_OVERLAP;
						for (int a = 0; a < 3; a++) begin
							it.c[a] = it.c[a + 3];
						end
					end
				endcase
				pending_items.push_back(it);
				made += 2;
			end else begin
				pending_items.push_back(it);
				made++;
			end
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		#0.5 arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		queue_op(aabb_pkg::FN_VOLUME, 0, 0, 0, 0, 0, 0);
		queue_op(aabb_pkg::FN_EMPTY, 0, 0, 0, 0, 0, 0);
		queue_op(aabb_pkg::FN_LOAD, -32768, -32768, -32768, 32767, 32767, 32767);
		queue_op(aabb_pkg::FN_VOLUME, 0, 0, 0, 0, 0, 0);
		queue_op(aabb_pkg::FN_SURFACE, 0, 0, 0, 0, 0, 0);
		queue_op(aabb_pkg::FN_PT_INSIDE, 0, 0, 0, 0, 0, 0);
		queue_op(aabb_pkg::FN_PT_INSIDE, -32768, 0, 0, 32767, 32767, 32767);
		queue_op(aabb_pkg::FN_BOX_INSIDE, -5, -5, -5, 5, 5, 5);
		queue_op(aabb_pkg::FN_INSIDE_EQ, -32768, -32768, -32768, 32767, 32767, 32767);
		queue_op(aabb_pkg::FN_LOAD, 10, 10, 10, -10, -10, -10);
		queue_op(aabb_pkg::FN_EMPTY, 0, 0, 0, 0, 0, 0);
		queue_op(aabb_pkg::FN_VOLUME, 0, 0, 0, 0, 0, 0);
		queue_op(aabb_pkg::FN_SURFACE, 0, 0, 0, 0, 0, 0);
		queue_op(aabb_pkg::FN_UNION_PT, 100, -100, 0, -1, -1, -1);
		queue_op(aabb_pkg::FN_UNION_BOX, -3, -3, -3, 200, 5, 5);
		queue_op(aabb_pkg::FN_OVERLAP, 200, 5, 5, 300, 50, 50);
		queue_op(aabb_pkg::FN_OVERLAP, 201, 0, 0, 300, 50, 50);
		queue_op(aabb_pkg::FN_INTERSECT, 0, 0, 0, -50, -50, -50);
		queue_op(aabb_pkg::FN_EMPTY, 0, 0, 0, 0, 0, 0);
		for (int c = int'(aabb_pkg::FN_SURFACE) + 1; c < 16; c++) begin
			queue_op(4'(c), 1, 2, 3, 4, 5, 6);
		end
		drain();

		queue_random_items(200);
		drain();
		send_gap_pct = 61;
		queue_random_items(200);
		drain();
		send_gap_pct = 0;
		stall_pct = 61;
		queue_random_items(200);
		drain();
		send_gap_pct = 10;
		stall_pct = 10;
		queue_random_items(200);
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
